[hw/rtl/lds_pkg.sv]
// Package with the state type, status codes and output widths of the linear Diophantine solver.
package lds_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EU_DIV,
    ST_EU_UPD,
    ST_FIN_DIV,
    ST_DONE
  } state_t;

  // Result status codes.
  localparam logic [1:0] STAT_GENERAL = 2'd0;
  localparam logic [1:0] STAT_NONE    = 2'd1;
  localparam logic [1:0] STAT_ANY     = 2'd2;
  localparam logic [1:0] STAT_SINGLE  = 2'd3;

  // Fixed widths of the result fields.
  localparam int unsigned FieldW  = 31;
  localparam int unsigned BaseW   = 64;
  localparam int unsigned OutDataW = 224;
  localparam int unsigned OutUserW = 3;

endpackage

[hw/rtl/linear_diophantine_solver_top.sv]
// Linear Diophantine solver: extended Euclid on one shared serial divide and multiply unit.
// Each Euclid step runs the shared divider, one quotient bit per cycle, and then an update
// state; the final c/g divide runs on the same divider. About 46 steps at most are needed.
// Throughput: one transaction at a time; the next is taken once the result is in the output
// register. Reset (rst_n, synchronous, active low) clears the sequencer and the output valid.
module linear_diophantine_solver_top #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // Input stream.
  input  logic in_tvalid,
  output logic in_tready,
  // Fields from bit 0 up: coef_a, coef_b, rhs_c, zero padding.
  input  logic [((3*DATA_WIDTH-2+7)/8)*8-1:0] in_tdata,
  // Result stream.
  output logic out_tvalid,
  input  logic out_tready,
  // Fields from bit 0 up: divisor, x_base, y_base, x_step, y_step, zero padding.
  output logic [lds_pkg::OutDataW-1:0] out_tdata,
  // Fields from bit 0 up: status, swapped.
  output logic [lds_pkg::OutUserW-1:0] out_tuser
);

  localparam int unsigned CW    = DATA_WIDTH - 1;
  localparam int unsigned SW    = DATA_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam int unsigned BW    = lds_pkg::BaseW;

  lds_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]         big_r, small_r, r0_r, r1_r;
  logic signed [SW-1:0]  s0_r, s1_r, t0_r, t1_r;
  logic [DATA_WIDTH-1:0] c_r;
  logic                  swp_r, zero_r;

  // Shared unit: restoring divider with two quotient-driven accumulators.
  logic [DATA_WIDTH-1:0] dvd_r;
  logic [CW-1:0]         dvsr_r, rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic signed [BW-1:0]  acc_x_r, acc_y_r;

  logic                  out_valid_r;
  logic [lds_pkg::OutDataW-1:0] out_data_r;
  logic [lds_pkg::OutUserW-1:0] out_user_r;

  // Input field split.
  logic [CW-1:0]         a_in, b_in;
  logic                  in_fire;
  assign a_in    = in_tdata[CW-1:0];
  assign b_in    = in_tdata[2*CW-1:CW];
  assign in_fire = in_tvalid && in_tready;

  // Divider step.
  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit, last;
  logic [CW-1:0]         rem_nxt;
  assign trial   = {rem_r, dvd_r[DATA_WIDTH-1]};
  assign diff    = {1'b0, trial} - {2'b0, dvsr_r};
  assign qbit    = ~diff[DATA_WIDTH];
  assign rem_nxt = qbit ? diff[CW-1:0] : trial[CW-1:0];
  assign last    = (cnt_r == CNT_W'(DATA_WIDTH - 1));

  // Multiply lanes: accumulate quotient bits MSB first times the selected coefficient.
  logic signed [SW-1:0] mop_x, mop_y;
  logic signed [BW-1:0] mx_ext, my_ext, acc_x_nxt, acc_y_nxt;
  assign mop_x  = (state_r == lds_pkg::ST_FIN_DIV) ? s0_r : s1_r;
  assign mop_y  = (state_r == lds_pkg::ST_FIN_DIV) ? t0_r : t1_r;
  assign mx_ext = {{(BW-SW){mop_x[SW-1]}}, mop_x};
  assign my_ext = {{(BW-SW){mop_y[SW-1]}}, mop_y};
  assign acc_x_nxt = {acc_x_r[BW-2:0], 1'b0} + (qbit ? mx_ext : '0);
  assign acc_y_nxt = {acc_y_r[BW-2:0], 1'b0} + (qbit ? my_ext : '0);

  // Euclid update values.
  logic signed [SW-1:0] s_new, t_new;
  assign s_new = s0_r - acc_x_r[SW-1:0];
  assign t_new = t0_r - acc_y_r[SW-1:0];

  // Magnitude of the right-hand side.
  logic                  c_neg;
  logic [DATA_WIDTH-1:0] c_abs;
  assign c_neg = c_r[DATA_WIDTH-1];
  assign c_abs = c_neg ? (~c_r + 1'b1) : c_r;

  logic out_slot;
  assign out_slot = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lds_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (a_in == '0 && b_in == '0) state_nxt = lds_pkg::ST_DONE;
          else if (a_in == '0 || b_in == '0) state_nxt = lds_pkg::ST_FIN_DIV;
          else state_nxt = lds_pkg::ST_EU_DIV;
        end
      end
      lds_pkg::ST_EU_DIV: begin
        if (last) state_nxt = lds_pkg::ST_EU_UPD;
      end
      lds_pkg::ST_EU_UPD: begin
        state_nxt = (rem_r == '0) ? lds_pkg::ST_FIN_DIV : lds_pkg::ST_EU_DIV;
      end
      lds_pkg::ST_FIN_DIV: begin
        if (last) state_nxt = lds_pkg::ST_DONE;
      end
      lds_pkg::ST_DONE: begin
        if (out_slot) state_nxt = lds_pkg::ST_IDLE;
      end
      default: state_nxt = lds_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready = (state_r == lds_pkg::ST_IDLE);
  end

  // Result assembly.
  logic [1:0]            res_status;
  logic [BW-1:0]         res_div, res_x, res_y, res_xs, res_ys;
  logic [SW-1:0]         s1_abs, t1_abs;
  assign s1_abs = s1_r[SW-1] ? -s1_r : s1_r;
  assign t1_abs = t1_r[SW-1] ? -t1_r : t1_r;

  always_comb begin
    res_status = lds_pkg::STAT_GENERAL;
    res_div    = BW'(r0_r);
    res_x      = '0;
    res_y      = '0;
    res_xs     = '0;
    res_ys     = '0;
    if (zero_r) begin
      res_status = (c_r == '0) ? lds_pkg::STAT_ANY : lds_pkg::STAT_NONE;
      res_div    = '0;
    end else if (rem_r != '0) begin
      res_status = lds_pkg::STAT_NONE;
    end else if (small_r == '0) begin
      res_status = lds_pkg::STAT_SINGLE;
      res_x      = c_neg ? -acc_x_r : acc_x_r;
    end else begin
      res_xs = BW'(s1_abs);
      res_ys = BW'(t1_abs);
      if (c_r == '0) begin
        res_x = BW'(small_r);
        res_y = -BW'(big_r);
      end else begin
        res_x = c_neg ? -acc_x_r : acc_x_r;
        res_y = c_neg ? -acc_y_r : acc_y_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lds_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lds_pkg::ST_DONE && out_slot) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      lds_pkg::ST_IDLE: begin
        if (in_fire) begin
          swp_r   <= (a_in < b_in);
          big_r   <= (a_in < b_in) ? b_in : a_in;
          small_r <= (a_in < b_in) ? a_in : b_in;
          r0_r    <= (a_in < b_in) ? b_in : a_in;
          r1_r    <= (a_in < b_in) ? a_in : b_in;
          c_r     <= in_tdata[3*DATA_WIDTH-3:2*CW];
          zero_r  <= (a_in == '0 && b_in == '0);
          s0_r    <= SW'(1);
          s1_r    <= '0;
          t0_r    <= '0;
          t1_r    <= SW'(1);
          rem_r   <= '0;
          cnt_r   <= '0;
          acc_x_r <= '0;
          acc_y_r <= '0;
          if (a_in < b_in) begin
            dvd_r  <= DATA_WIDTH'(b_in);
            dvsr_r <= a_in;
          end else begin
            dvd_r  <= DATA_WIDTH'(a_in);
            dvsr_r <= b_in;
          end
          // A single nonzero coefficient goes straight to the c/g divide.
          if (a_in == '0 || b_in == '0) begin
            dvd_r  <= in_tdata[3*DATA_WIDTH-3] ? (~in_tdata[3*DATA_WIDTH-3:2*CW] + 1'b1)
                                               : in_tdata[3*DATA_WIDTH-3:2*CW];
            dvsr_r <= (a_in < b_in) ? b_in : a_in;
          end
        end
      end
      lds_pkg::ST_EU_DIV, lds_pkg::ST_FIN_DIV: begin
        dvd_r   <= {dvd_r[DATA_WIDTH-2:0], 1'b0};
        rem_r   <= rem_nxt;
        acc_x_r <= acc_x_nxt;
        acc_y_r <= acc_y_nxt;
        cnt_r   <= cnt_r + 1'b1;
      end
      lds_pkg::ST_EU_UPD: begin
        r0_r    <= r1_r;
        r1_r    <= rem_r;
        s0_r    <= s1_r;
        s1_r    <= s_new;
        t0_r    <= t1_r;
        t1_r    <= t_new;
        cnt_r   <= '0;
        acc_x_r <= '0;
        acc_y_r <= '0;
        dvsr_r  <= (rem_r == '0) ? r1_r : rem_r;
        dvd_r   <= (rem_r == '0) ? c_abs : DATA_WIDTH'(r1_r);
        rem_r   <= '0;
      end
      lds_pkg::ST_DONE: begin
        if (out_slot) begin
          out_user_r <= {swp_r, res_status};
          out_data_r <= {3'b0, res_ys[lds_pkg::FieldW-1:0], res_xs[lds_pkg::FieldW-1:0],
                         res_y, res_x, res_div[lds_pkg::FieldW-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[sim/tb_linear_diophantine_solver_top.sv]
// Testbench for the linear Diophantine solver: directed, random and backpressure tests.
module tb_linear_diophantine_solver_top;

  localparam int unsigned DW  = 32;
  localparam int unsigned INW = ((3*DW-2+7)/8)*8;
  localparam logic [30:0] COEF_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] RHS_MIN  = 32'h8000_0000;
  localparam logic [31:0] RHS_MAX  = 32'h7FFF_FFFF;
  localparam logic [30:0] FIB_BIG  = 31'd1836311903;
  localparam logic [30:0] FIB_SMALL = 31'd1134903170;
  localparam int unsigned HOLD_CYCLES = 3000;

  // One expected solution, field by field.
  typedef struct {
    logic [1:0]  status;
    logic        swapped;
    logic [30:0] divisor;
    longint      x_base;
    longint      y_base;
    logic [30:0] x_step;
    logic [30:0] y_step;
  } solution_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [INW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [lds_pkg::OutDataW-1:0] out_tdata;
  logic [lds_pkg::OutUserW-1:0] out_tuser;

  solution_t pending_solutions[$];
  int  mismatch_cnt;
  bit  calm_mode;
  bit  pressure_req;

  linear_diophantine_solver_top #(.DATA_WIDTH(DW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Solve a*x + b*y = c the way the block should, with extended Euclid.
  function automatic solution_t solve_equation(logic [30:0] a, logic [30:0] b,
                                               logic [31:0] c_raw);
    solution_t sol;
    longint c;
    longint big;
    longint sml;
    longint r0, r1, s0, s1, t0, t1, q, tmp, g;
    sol = '{lds_pkg::STAT_GENERAL, 1'b0, 31'd0, 64'sd0, 64'sd0, 31'd0, 31'd0};
    c = longint'($signed(c_raw));
    sol.swapped = (a < b);
    big = sol.swapped ? longint'(b) : longint'(a);
    sml = sol.swapped ? longint'(a) : longint'(b);
    if (big == 0) begin
      sol.status = (c == 0) ? lds_pkg::STAT_ANY : lds_pkg::STAT_NONE;
      return sol;
    end
    r0 = big; r1 = sml;
    s0 = 1; s1 = 0;
    t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = s0 - q * s1; s0 = s1; s1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    g = r0;
    sol.divisor = g[30:0];
    if (c % g != 0) begin
      sol.status = lds_pkg::STAT_NONE;
    end else if (sml == 0) begin
      sol.status = lds_pkg::STAT_SINGLE;
      sol.x_base = c / big;
    end else if (c == 0) begin
      sol.x_base = sml;
      sol.y_base = -big;
      sol.x_step = 31'(sml / g);
      sol.y_step = 31'(big / g);
    end else begin
      sol.x_base = s0 * (c / g);
      sol.y_base = t0 * (c / g);
      sol.x_step = 31'(sml / g);
      sol.y_step = 31'(big / g);
    end
    return sol;
  endfunction

  // Offer one equation and wait until the block takes it; called at a falling edge.
  task automatic send_equation(logic [30:0] a, logic [30:0] b, logic [31:0] c);
    if (!calm_mode && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, c, b, a};
    do @(posedge clk); while (!in_tready);
    pending_solutions.insert(pending_solutions.size(), solve_equation(a, b, c));
    @(negedge clk);
  endtask

  // Random 31-bit coefficient, often small so that short Euclid chains appear too.
  function automatic logic [30:0] rand_coef();
    case ($urandom_range(3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 100));
      2: return 31'($urandom_range(0, 65535));
      default: return 31'($urandom()) >> $urandom_range(0, 30);
    endcase
  endfunction

  // Random equation; most have a right-hand side that the gcd divides.
  task automatic send_random_equation();
    logic [30:0] a;
    logic [30:0] b;
    logic [31:0] c;
    longint g;
    longint k;
    a = rand_coef();
    b = rand_coef();
    if ($urandom_range(9) < 2) begin
      g = longint'($urandom_range(1, 1000));
      a = 31'((longint'(a) / g) * g);
      b = 31'((longint'(b) / g) * g);
    end
    c = $urandom();
    case ($urandom_range(9))
      0: c = 32'd0;
      1, 2: ;
      default: begin
        g = longint'(solve_equation(a, b, 32'd0).divisor);
        if (g != 0) begin
          k = longint'($signed(c)) / g;
          c = 32'(k * g);
        end
      end
    endcase
    send_equation(a, b, c);
  endtask

  // Extremes, every status and each special case.
  task automatic test_directed();
    send_equation(31'd0, 31'd0, 32'd0);
    send_equation(31'd0, 31'd0, 32'd5);
    send_equation(31'd0, 31'd0, RHS_MIN);
    send_equation(31'd7, 31'd0, 32'd21);
    send_equation(31'd0, 31'd7, -32'sd21);
    send_equation(31'd7, 31'd0, 32'd22);
    send_equation(COEF_MAX, 31'd0, RHS_MAX);
    send_equation(31'd6, 31'd4, 32'd0);
    send_equation(31'd4, 31'd6, 32'd0);
    send_equation(31'd6, 31'd4, 32'd3);
    send_equation(31'd6, 31'd4, 32'd10);
    send_equation(31'd4, 31'd6, -32'sd10);
    send_equation(COEF_MAX, COEF_MAX, RHS_MAX);
    send_equation(COEF_MAX, COEF_MAX, 32'd0);
    send_equation(COEF_MAX, 31'd1, RHS_MIN);
    send_equation(FIB_BIG, FIB_SMALL, -32'sd1);
    send_equation(FIB_SMALL, FIB_BIG, RHS_MAX);
    send_equation(FIB_BIG, FIB_SMALL, RHS_MIN);
    send_equation(31'd1, 31'd1, -32'sd1);
    send_equation(COEF_MAX, COEF_MAX - 31'd1, 32'd1);
    send_equation(31'd12, 31'd18, RHS_MIN);
    send_equation(31'd2, 31'd4, RHS_MIN);
    send_equation(31'd1, 31'd0, RHS_MIN);
    send_equation(31'd0, 31'd1, RHS_MAX);
  endtask

  // Random equations with idling on both sides.
  task automatic test_random(int unsigned count);
    repeat (count) send_random_equation();
  endtask

  // The receiver holds off while equations keep coming, so the input stalls.
  task automatic test_backpressure();
    pressure_req = 1'b1;
    repeat (6) send_random_equation();
  endtask

  // Random equations with no idling at all.
  task automatic test_back_to_back();
    calm_mode = 1'b1;
    repeat (40) send_random_equation();
    calm_mode = 1'b0;
  endtask

  // Result side: random holds, plus one long hold-off on request.
  always @(negedge clk) begin : result_ready_gen
    static int unsigned hold_left = 0;
    static bit hold_done = 1'b0;
    if (pressure_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  // Compare each result transaction with the oldest expected solution.
  always @(posedge clk) begin : result_check
    solution_t exp_sol;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_solutions.size() == 0) begin
        $error("result with no equation pending");
        mismatch_cnt++;
      end else begin
        exp_sol = pending_solutions.pop_front();
        if (out_tuser[1:0] !== exp_sol.status) begin
          $error("status: expected %0d, got %0d", exp_sol.status, out_tuser[1:0]);
          mismatch_cnt++;
        end
        if (out_tuser[2] !== exp_sol.swapped) begin
          $error("swapped: expected %0d, got %0d", exp_sol.swapped, out_tuser[2]);
          mismatch_cnt++;
        end
        if (out_tdata[30:0] !== exp_sol.divisor) begin
          $error("divisor: expected %0d, got %0d", exp_sol.divisor, out_tdata[30:0]);
          mismatch_cnt++;
        end
        if (out_tdata[94:31] !== exp_sol.x_base) begin
          $error("x_base: expected %0d, got %0d", exp_sol.x_base,
                 $signed(out_tdata[94:31]));
          mismatch_cnt++;
        end
        if (out_tdata[158:95] !== exp_sol.y_base) begin
          $error("y_base: expected %0d, got %0d", exp_sol.y_base,
                 $signed(out_tdata[158:95]));
          mismatch_cnt++;
        end
        if (out_tdata[189:159] !== exp_sol.x_step) begin
          $error("x_step: expected %0d, got %0d", exp_sol.x_step, out_tdata[189:159]);
          mismatch_cnt++;
        end
        if (out_tdata[220:190] !== exp_sol.y_step) begin
          $error("y_step: expected %0d, got %0d", exp_sol.y_step, out_tdata[220:190]);
          mismatch_cnt++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    mismatch_cnt = 0;
    calm_mode = 1'b0;
    pressure_req = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(120);
    test_backpressure();
    test_back_to_back();
    test_random(140);
    in_tvalid <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatch_cnt == 0 && pending_solutions.size() == 0) begin
      $display("tb_linear_diophantine_solver_top passed");
    end else begin
      $display("tb_linear_diophantine_solver_top failed");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #50_000_000;
    $display("tb_linear_diophantine_solver_top failed");
    $finish;
  end

endmodule
